>>> rtl/core/pvfw_pkg.sv
package pvfw_pkg;

  localparam int CUBE_X_DEF    = 8;
  localparam int BYTES_PER_X   = 96;   // one 8x8 plane of 12-bit voxels
  localparam int GS_W          = 12;
  localparam int LEVEL_W       = 15;
  localparam int BYTE_POS_W    = 10;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 15'd28671;
  localparam logic [GS_W-1:0]    GS_MAX    = 12'hfff;

  typedef enum logic [1:0] {
    ACT_PLOT  = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  // First byte of voxel {x,y,z}: (12*v) >> 3 == (3*v) >> 1
  function automatic logic [BYTE_POS_W-1:0] voxel_byte_pos(input logic [2:0] x,
                                                           input logic [2:0] y,
                                                           input logic [2:0] z);
    logic [8:0]  v;
    logic [10:0] t;
    v = {x, y, z};
    t = {2'b00, v} + {1'b0, v, 1'b0};
    return t[10:1];
  endfunction

endpackage

>>> rtl/core/pvfw_store.sv
module pvfw_store #(
  parameter int DEPTH = 768,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata_r
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

>>> rtl/core/packed_voxel_frame_writer.sv
// Set runs ST_RDA, ST_RDB, ST_WRA, ST_WRB; plot runs them once per voxel; read runs ST_READ, ST_RDOUT.
// Start is taken only in idle: a new transaction waits until the last one is done and busy is low.
// Each voxel is a read-modify-write of two bytes through the one-byte store: two reads, two
// writes; clear writes one byte per cycle over the whole store.
// Reset (rst_n low, synchronous) starts a clearing pass over all 96*CUBE_X bytes, busy held high.
// Every transaction gives exactly one strobe; the receiver cannot stall.
module packed_voxel_frame_writer #(
  parameter int CUBE_X = pvfw_pkg::CUBE_X_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    in_action,
  input  logic [2:0]                    in_x,
  input  logic [2:0]                    in_y,
  input  logic [2:0]                    in_z,
  input  logic [pvfw_pkg::GS_W-1:0]     in_intensity,
  input  logic [pvfw_pkg::LEVEL_W-1:0]  in_level,
  input  logic [9:0]                    in_byte_address,
  output logic                          out_valid,
  output logic [7:0]                    out_read_data
);
  import pvfw_pkg::*;

  localparam int DEPTH = CUBE_X * BYTES_PER_X;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLR, ST_READ, ST_RDOUT, ST_RDA, ST_RDB, ST_WRA, ST_WRB
  } state_t;

  state_t              state_r;
  logic [2:0]          x_r, y_r, z_r;
  logic [GS_W-1:0]     val_r, val2_r;
  logic                second_r;
  logic                clr_emit_r;
  logic [AW-1:0]       clr_addr_r;
  logic [9:0]          rd_addr_r;
  logic                rd_ok_r;
  logic [7:0]          hi_r, lo_r;
  logic                out_valid_r;
  logic [7:0]          out_data_r;

  logic [BYTE_POS_W-1:0] bp;
  logic [AW-1:0]         bp_a, bp_b;
  logic [15:0]           pair, pair_new;
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [7:0]            mem_wdata, mem_rdata;
  logic [LEVEL_W-1:0]    lvl_sat;
  logic                  x_ok;

  assign bp   = voxel_byte_pos(x_r, y_r, z_r);
  assign bp_a = AW'(bp);
  assign bp_b = bp_a + AW'(1);

  // odd voxel owns the low 12 bits of its byte pair
  assign pair     = {hi_r, mem_rdata};
  assign pair_new = z_r[0] ? {pair[15:12], val_r} : {val_r, pair[3:0]};

  assign lvl_sat = (in_level > LEVEL_MAX) ? LEVEL_MAX : in_level;
  assign x_ok    = (32'(in_x) < CUBE_X);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = bp_a;
    mem_wdata = 8'd0;
    mem_raddr = bp_a;
    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      ST_READ: mem_raddr = AW'(rd_addr_r);
      ST_RDB:  mem_raddr = bp_b;
      ST_WRA: begin
        mem_we    = 1'b1;
        mem_wdata = pair_new[15:8];
      end
      ST_WRB: begin
        mem_we    = 1'b1;
        mem_waddr = bp_b;
        mem_wdata = lo_r;
      end
      default: ;
    endcase
  end

  pvfw_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (mem_waddr),
    .wdata   (mem_wdata),
    .raddr   (mem_raddr),
    .rdata_r (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_addr_r  <= '0;
      clr_emit_r  <= 1'b0;
      second_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (start) begin
            x_r        <= in_x;
            y_r        <= in_y;
            rd_addr_r  <= in_byte_address;
            rd_ok_r    <= (32'(in_byte_address) < DEPTH);
            second_r   <= 1'b0;
            out_data_r <= 8'd0;
            case (action_t'(in_action))
              ACT_PLOT: begin
                z_r      <= lvl_sat[14:12];
                val_r    <= GS_MAX - lvl_sat[11:0];
                val2_r   <= lvl_sat[11:0];
                second_r <= 1'b1;
                if (x_ok) begin
                  state_r <= ST_RDA;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              ACT_SET: begin
                z_r   <= in_z;
                val_r <= in_intensity;
                if (x_ok) begin
                  state_r <= ST_RDA;
                end else begin
                  out_valid_r <= 1'b1;
                end
              end
              ACT_CLEAR: begin
                clr_addr_r <= '0;
                clr_emit_r <= 1'b1;
                state_r    <= ST_CLR;
              end
              default: state_r <= ST_READ;
            endcase
          end
        end
        ST_CLR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == AW'(DEPTH - 1)) begin
            state_r     <= ST_IDLE;
            out_valid_r <= clr_emit_r;
            out_data_r  <= 8'd0;
            clr_emit_r  <= 1'b0;
          end
        end
        ST_READ: state_r <= ST_RDOUT;
        ST_RDOUT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= rd_ok_r ? mem_rdata : 8'd0;
          state_r     <= ST_IDLE;
        end
        ST_RDA: state_r <= ST_RDB;
        ST_RDB: begin
          hi_r    <= mem_rdata;
          state_r <= ST_WRA;
        end
        ST_WRA: begin
          lo_r    <= pair_new[7:0];
          state_r <= ST_WRB;
        end
        ST_WRB: begin
          // second plot voxel reads only after both bytes of the first are written
          if (second_r) begin
            second_r <= 1'b0;
            z_r      <= z_r + 3'd1;
            val_r    <= val2_r;
            state_r  <= ST_RDA;
          end else begin
            out_valid_r <= 1'b1;
            out_data_r  <= 8'd0;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

>>> test/packed_voxel_frame_writer_test.sv
`timescale 1ns / 1ps

module packed_voxel_frame_writer_test;
  import pvfw_pkg::*;

  localparam int STORE_BYTES = CUBE_X_DEF * BYTES_PER_X;
  localparam int RANDOM_ITEMS = 1250;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [1:0]           in_action;
  logic [2:0]           in_x;
  logic [2:0]           in_y;
  logic [2:0]           in_z;
  logic [GS_W-1:0]      in_intensity;
  logic [LEVEL_W-1:0]   in_level;
  logic [9:0]           in_byte_address;
  logic                 out_valid;
  logic [7:0]           out_read_data;

  // shadow copy of the packed frame store and the bytes still owed by the block
  logic [7:0] frame_img [0:STORE_BYTES-1];
  logic [7:0] expected_bytes [$];
  logic [7:0] oldest_byte;
  int         mismatch_cnt;

  packed_voxel_frame_writer uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_action      (in_action),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_z           (in_z),
    .in_intensity   (in_intensity),
    .in_level       (in_level),
    .in_byte_address(in_byte_address),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic int voxel_first_byte(input logic [2:0] x, input logic [2:0] y,
                                          input logic [2:0] z);
    return (12 * int'({x, y, z})) >> 3;
  endfunction

  // even voxels take the top 12 bits of their byte pair, odd ones the low 12
  task automatic write_voxel_img(input logic [2:0] x, input logic [2:0] y,
                                 input logic [2:0] z, input logic [GS_W-1:0] val);
    int          bit_pos;
    int          bp;
    logic [15:0] pair;
    bit_pos = 12 * int'({x, y, z});
    bp = bit_pos >> 3;
    pair = {frame_img[bp], frame_img[bp + 1]};
    if ((bit_pos & 7) != 0) begin
      pair = {pair[15:12], val};
    end else begin
      pair = {val, pair[3:0]};
    end
    frame_img[bp] = pair[15:8];
    frame_img[bp + 1] = pair[7:0];
  endtask

  task automatic predict_frame_op(input action_t act, input logic [2:0] x, input logic [2:0] y,
                                  input logic [2:0] z, input logic [GS_W-1:0] gs,
                                  input logic [LEVEL_W-1:0] lvl, input logic [9:0] addr,
                                  output logic [7:0] rd);
    logic [LEVEL_W-1:0] sat;
    logic [2:0]         lz;
    logic [GS_W-1:0]    frac;
    rd = 8'h00;
    case (act)
      ACT_PLOT: begin
        sat = (lvl > LEVEL_MAX) ? LEVEL_MAX : lvl;
        lz = sat[14:12];
        frac = sat[11:0];
        write_voxel_img(x, y, lz, GS_MAX - frac);
        write_voxel_img(x, y, lz + 3'd1, frac);
      end
      ACT_SET: begin
        write_voxel_img(x, y, z, gs);
      end
      ACT_CLEAR: begin
        foreach (frame_img[i]) frame_img[i] = 8'h00;
      end
      default: begin
        if (int'(addr) < STORE_BYTES) rd = frame_img[addr];
      end
    endcase
  endtask

  // leaves start high so back-to-back transactions need no extra edge
  task automatic send_item(input action_t act, input logic [2:0] x, input logic [2:0] y,
                           input logic [2:0] z, input logic [GS_W-1:0] gs,
                           input logic [LEVEL_W-1:0] lvl, input logic [9:0] addr);
    logic [7:0] rd;
    @(negedge clk);
    start           <= 1'b1;
    in_action       <= act;
    in_x            <= x;
    in_y            <= y;
    in_z            <= z;
    in_intensity    <= gs;
    in_level        <= lvl;
    in_byte_address <= addr;
    do @(posedge clk); while (busy);
    predict_frame_op(act, x, y, z, gs, lvl, addr, rd);
    expected_bytes.push_back(rd);
  endtask

  task automatic hold_off(input int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic wait_all_bytes_seen();
    @(negedge clk);
    start <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk);
  endtask

  task automatic read_byte(input int addr);
    send_item(ACT_READ, 3'd0, 3'd0, 3'd0, '0, '0, addr[9:0]);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid !== 1'b0) begin
      if (expected_bytes.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
          $display("mismatch at %0t: strobe with nothing pending, read_data %02h",
                   $time, out_read_data);
      end else begin
        oldest_byte = expected_bytes.pop_front();
        if (out_read_data !== oldest_byte) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("mismatch at %0t: read_data expected %02h got %02h",
                     $time, oldest_byte, out_read_data);
        end
      end
    end
  end

  task automatic test_reads_after_reset();
    read_byte(0);
    read_byte(STORE_BYTES - 1);
    read_byte(STORE_BYTES);        // past the end reads zero
    read_byte(1023);
  endtask

  task automatic test_set_packing();
    send_item(ACT_SET, 3'd0, 3'd0, 3'd0, GS_MAX, '0, '0);
    send_item(ACT_SET, 3'd0, 3'd0, 3'd1, GS_MAX, '0, '0);
    send_item(ACT_SET, 3'd7, 3'd7, 3'd7, GS_MAX, '1, '1);
    send_item(ACT_SET, 3'd7, 3'd7, 3'd6, 12'ha5c, '1, '1);
    hold_off(3);
    read_byte(0);
    read_byte(1);
    read_byte(2);
    read_byte(STORE_BYTES - 3);
    read_byte(STORE_BYTES - 2);
    read_byte(STORE_BYTES - 1);
  endtask

  task automatic test_plot_levels();
    send_item(ACT_PLOT, 3'd3, 3'd4, 3'd0, '0, 15'd0, '0);
    send_item(ACT_PLOT, 3'd3, 3'd5, 3'd0, '0, 15'd4095, '0);
    send_item(ACT_PLOT, 3'd3, 3'd6, 3'd0, '0, LEVEL_MAX, '0);
    send_item(ACT_PLOT, 3'd2, 3'd1, 3'd0, '0, LEVEL_MAX + 15'd1, '0);
    send_item(ACT_PLOT, 3'd2, 3'd2, 3'd7, '1, 15'h7fff, '0);
    read_byte(voxel_first_byte(3'd3, 3'd5, 3'd0));
    read_byte(voxel_first_byte(3'd3, 3'd5, 3'd0) + 1);
    read_byte(voxel_first_byte(3'd2, 3'd1, 3'd7) + 1);
  endtask

  task automatic test_clear();
    wait_all_bytes_seen();
    send_item(ACT_CLEAR, 3'd7, 3'd7, 3'd7, '1, '1, '1);
    read_byte(0);
    read_byte(voxel_first_byte(3'd3, 3'd6, 3'd6));
    read_byte(STORE_BYTES - 1);
  endtask

  task automatic test_random_traffic();
    int                 i;
    int                 pick;
    int                 burst_left;
    action_t            act;
    logic [2:0]         x, y, z;
    logic [2:0]         hx, hy, hz;
    logic [GS_W-1:0]    gs;
    logic [LEVEL_W-1:0] lvl;
    logic [9:0]         addr;
    burst_left = 0;
    hx = 3'd0;
    hy = 3'd0;
    hz = 3'd0;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(0, 99);
      x    = 3'($urandom_range(0, 7));
      y    = 3'($urandom_range(0, 7));
      z    = 3'($urandom_range(0, 7));
      gs   = GS_W'($urandom);
      lvl  = LEVEL_W'($urandom);
      addr = 10'($urandom);
      if ($urandom_range(0, 7) == 0) gs = $urandom_range(0, 1) ? GS_MAX : '0;
      if ($urandom_range(0, 15) == 0) lvl = {3'($urandom_range(0, 7)), 12'hfff};
      if (pick < 2) act = ACT_CLEAR;
      else if (pick < 36) act = ACT_SET;
      else if (pick < 60) act = ACT_PLOT;
      else act = ACT_READ;
      // half the reads go to the bytes of, or just after, the voxel touched last
      if (act == ACT_READ && $urandom_range(0, 1) == 1)
        addr = 10'(voxel_first_byte(hx, hy, hz) + $urandom_range(0, 2));
      if (act == ACT_SET || act == ACT_PLOT) begin
        hx = x;
        hy = y;
        hz = (act == ACT_SET) ? z : ((lvl > LEVEL_MAX) ? 3'd6 : lvl[14:12]);
        if (act == ACT_PLOT && $urandom_range(0, 1) == 1) hz = hz + 3'd1;
      end
      if (burst_left == 0) begin
        hold_off($urandom_range(1, 15));
        burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                 : $urandom_range(1, 10);
      end
      burst_left--;
      if ($urandom_range(0, 149) == 0) wait_all_bytes_seen();
      send_item(act, x, y, z, gs, lvl, addr);
    end
  endtask

  initial begin
    int guard;
    mismatch_cnt    = 0;
    rst_n           = 1'b0;
    start           = 1'b0;
    in_action       = ACT_PLOT;
    in_x            = '0;
    in_y            = '0;
    in_z            = '0;
    in_intensity    = '0;
    in_level        = '0;
    in_byte_address = '0;
    foreach (frame_img[i]) frame_img[i] = 8'h00;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reads_after_reset();
    test_set_packing();
    test_plot_levels();
    test_clear();
    test_random_traffic();

    @(negedge clk);
    start <= 1'b0;
    guard = 0;
    while (expected_bytes.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (mismatch_cnt == 0 && expected_bytes.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> packed_voxel_frame_writer.f
rtl/core/pvfw_pkg.sv
rtl/core/pvfw_store.sv
rtl/core/packed_voxel_frame_writer.sv
test/packed_voxel_frame_writer_test.sv
